>>> rtl/core/pft_pkg.sv
// types, widths and latencies shared by the three-point parabola fit
// no dependencies; imported by every module of the block

package pft_pkg;

  // coordinate format, fixed by the transaction layout
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS_DEF = 16;

  // intermediate widths of the closed-form solve
  localparam int CHUNK = COORD_WIDTH + 1;
  localparam int DEN_WIDTH = 3 * COORD_WIDTH + 3;
  localparam int NA_WIDTH = 2 * COORD_WIDTH + 3;
  localparam int NB_WIDTH = 3 * COORD_WIDTH + 3;
  localparam int NC_WIDTH = 4 * COORD_WIDTH + 3;

  // pipeline depths
  localparam int MUL_LAT = 2;
  localparam int NUM_LAT = 4 + 2 * MUL_LAT;
  localparam int DIV_LAT = COORD_WIDTH + 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic   mode;
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
    coord_t third_x;
    coord_t third_y;
  } point_t;

  typedef struct packed {
    coord_t coef_square;
    coord_t coef_linear;
    coord_t coef_const;
    logic   singular;
    logic   saturated;
  } coef_t;

  // flags that travel alongside the datapath
  typedef struct packed {
    logic valid;
    logic sing;
  } nflag_t;

endpackage

>>> rtl/core/pft_mul.sv
// two-stage signed multiplier built from chunk-sized partial products
// depends on pft_pkg (chunk width)

module pft_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [AW-1:0]      a,
  input  logic signed [BW-1:0]      b,
  output logic signed [AW+BW-1:0]   p
);
  import pft_pkg::*;

  localparam int NA = (AW + CHUNK - 1) / CHUNK;
  localparam int NB = (BW + CHUNK - 1) / CHUNK;
  localparam int PW = 2 * CHUNK + 2;
  localparam int SW = (NA + NB) * CHUNK;

  logic signed [NA*CHUNK-1:0] a_ext;
  logic signed [NB*CHUNK-1:0] b_ext;
  logic signed [CHUNK:0]      ac [NA];
  logic signed [CHUNK:0]      bc [NB];
  logic signed [PW-1:0]       pp [NA*NB];
  logic signed [SW-1:0]       acc;

  assign a_ext = (NA*CHUNK)'(a);
  assign b_ext = (NB*CHUNK)'(b);

  // split operands: lower chunks unsigned, top chunk signed
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) ac[i] = {a_ext[i*CHUNK+CHUNK-1], a_ext[i*CHUNK +: CHUNK]};
      else ac[i] = {1'b0, a_ext[i*CHUNK +: CHUNK]};
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) bc[j] = {b_ext[j*CHUNK+CHUNK-1], b_ext[j*CHUNK +: CHUNK]};
      else bc[j] = {1'b0, b_ext[j*CHUNK +: CHUNK]};
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i*NB+j] <= ac[i] * bc[j];
        end
      end
    end
  end

  // weighted sum of partial products
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp[i*NB+j]) <<< ((i + j) * CHUNK));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc[AW+BW-1:0];
    end
  end

endmodule

>>> rtl/core/pft_numer.sv
// front pipeline: coordinate swap, differences, products and the
// cramer numerators and denominator; depends on pft_pkg and pft_mul

module pft_numer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  pt_valid,
  input  pft_pkg::point_t                       pt,
  output pft_pkg::nflag_t                       flag,
  output logic signed [pft_pkg::DEN_WIDTH-1:0]  den,
  output logic signed [pft_pkg::NA_WIDTH-1:0]   na,
  output logic signed [pft_pkg::NB_WIDTH-1:0]   nb,
  output logic signed [pft_pkg::NC_WIDTH-1:0]   nc
);
  import pft_pkg::*;

  localparam int W = COORD_WIDTH;

  nflag_t fl [NUM_LAT];

  logic signed [W-1:0]     u [3];
  logic signed [W-1:0]     v [3];
  logic signed [W-1:0]     u2 [3];
  logic signed [W-1:0]     v2 [3];
  logic signed [W:0]       d12, d13, d23;

  logic signed [2*W+1:0]   p1213;
  logic signed [2*W-1:0]   sq [3];
  logic signed [2*W-1:0]   w [3];
  logic signed [2*W:0]     ta [3];
  logic signed [W-1:0]     v_m [2][3];
  logic signed [W:0]       d23_m [2];

  logic signed [NA_WIDTH-1:0] na_s5;
  logic signed [2*W:0]     e [3];
  logic signed [2*W+1:0]   p_s5;
  logic signed [W:0]       d23_s5;
  logic signed [W-1:0]     v_s5 [3];
  logic signed [2*W:0]     ta_s5 [3];
  logic signed [2*W-1:0]   w_s5 [3];

  logic signed [DEN_WIDTH-1:0] den_m;
  logic signed [3*W:0]     nbp [3];
  logic signed [4*W:0]     ncp [3];
  logic signed [NA_WIDTH-1:0] na_m [2];

  // flag line, singular when two abscissas coincide
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_LAT; k++) fl[k] <= '0;
    end else if (en) begin
      fl[0] <= '{valid: pt_valid, sing: 1'b0};
      fl[1] <= '{valid: fl[0].valid,
                 sing: (u[0] == u[1]) || (u[0] == u[2]) || (u[1] == u[2])};
      for (int k = 2; k < NUM_LAT; k++) fl[k] <= fl[k-1];
    end
  end

  assign flag = fl[NUM_LAT-1];

  // stage 1: pick abscissa and ordinate per mode
  always_ff @(posedge clk) begin
    if (en) begin
      u[0] <= pt.mode ? pt.first_y  : pt.first_x;
      v[0] <= pt.mode ? pt.first_x  : pt.first_y;
      u[1] <= pt.mode ? pt.second_y : pt.second_x;
      v[1] <= pt.mode ? pt.second_x : pt.second_y;
      u[2] <= pt.mode ? pt.third_y  : pt.third_x;
      v[2] <= pt.mode ? pt.third_x  : pt.third_y;
    end
  end

  // stage 2: abscissa differences
  always_ff @(posedge clk) begin
    if (en) begin
      d12 <= (W+1)'(u[0]) - (W+1)'(u[1]);
      d13 <= (W+1)'(u[0]) - (W+1)'(u[2]);
      d23 <= (W+1)'(u[1]) - (W+1)'(u[2]);
      u2  <= u;
      v2  <= v;
    end
  end

  // first multiply bank
  pft_mul #(.AW(W+1), .BW(W+1)) u_p1213 (
    .clk(clk), .en(en), .a(d12), .b(d13), .p(p1213)
  );
  pft_mul #(.AW(W+1), .BW(W)) u_ta0 (
    .clk(clk), .en(en), .a(d23), .b(v2[0]), .p(ta[0])
  );
  pft_mul #(.AW(W+1), .BW(W)) u_ta1 (
    .clk(clk), .en(en), .a(d13), .b(v2[1]), .p(ta[1])
  );
  pft_mul #(.AW(W+1), .BW(W)) u_ta2 (
    .clk(clk), .en(en), .a(d12), .b(v2[2]), .p(ta[2])
  );
  pft_mul #(.AW(W), .BW(W)) u_w0 (
    .clk(clk), .en(en), .a(u2[1]), .b(u2[2]), .p(w[0])
  );
  pft_mul #(.AW(W), .BW(W)) u_w1 (
    .clk(clk), .en(en), .a(u2[2]), .b(u2[0]), .p(w[1])
  );
  pft_mul #(.AW(W), .BW(W)) u_w2 (
    .clk(clk), .en(en), .a(u2[0]), .b(u2[1]), .p(w[2])
  );

  for (genvar i = 0; i < 3; i++) begin : g_sq
    pft_mul #(.AW(W), .BW(W)) u_sq (
      .clk(clk), .en(en), .a(u2[i]), .b(u2[i]), .p(sq[i])
    );
  end

  // operands that wait for the first bank
  always_ff @(posedge clk) begin
    if (en) begin
      v_m[0]   <= v2;
      v_m[1]   <= v_m[0];
      d23_m[0] <= d23;
      d23_m[1] <= d23_m[0];
    end
  end

  // stage 5: a numerator and square differences
  always_ff @(posedge clk) begin
    if (en) begin
      na_s5  <= NA_WIDTH'(ta[0]) - NA_WIDTH'(ta[1]) + NA_WIDTH'(ta[2]);
      e[0]   <= (2*W+1)'(sq[2]) - (2*W+1)'(sq[1]);
      e[1]   <= (2*W+1)'(sq[0]) - (2*W+1)'(sq[2]);
      e[2]   <= (2*W+1)'(sq[1]) - (2*W+1)'(sq[0]);
      p_s5   <= p1213;
      d23_s5 <= d23_m[1];
      v_s5   <= v_m[1];
      ta_s5  <= ta;
      w_s5   <= w;
    end
  end

  // second multiply bank
  pft_mul #(.AW(2*W+2), .BW(W+1)) u_den (
    .clk(clk), .en(en), .a(p_s5), .b(d23_s5), .p(den_m)
  );

  for (genvar i = 0; i < 3; i++) begin : g_num
    pft_mul #(.AW(2*W+1), .BW(W)) u_nb (
      .clk(clk), .en(en), .a(e[i]), .b(v_s5[i]), .p(nbp[i])
    );
    pft_mul #(.AW(2*W+1), .BW(2*W)) u_nc (
      .clk(clk), .en(en), .a(ta_s5[i]), .b(w_s5[i]), .p(ncp[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_m[0] <= na_s5;
      na_m[1] <= na_m[0];
    end
  end

  // stage 8: b and c numerators; denominator and a numerator registered alongside
  always_ff @(posedge clk) begin
    if (en) begin
      den <= den_m;
      na  <= na_m[1];
      nb  <= NB_WIDTH'(nbp[0]) + NB_WIDTH'(nbp[1]) + NB_WIDTH'(nbp[2]);
      nc  <= NC_WIDTH'(ncp[0]) - NC_WIDTH'(ncp[1]) + NC_WIDTH'(ncp[2]);
    end
  end

endmodule

>>> rtl/core/pft_div.sv
// pipelined restoring divider, one quotient bit per stage, with
// round-half-away rounding and saturation; depends on pft_pkg

module pft_div #(
  parameter int NW = 131,
  parameter int DW = 99
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output pft_pkg::coord_t      q,
  output logic                 sat
);
  import pft_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int QW = W + 1;
  localparam int HW = NW + 1 - QW;
  localparam int XW = (HW > DW) ? HW : DW;
  localparam logic [QW-1:0] LIM_NEG = QW'(1) << (W - 1);
  localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

  logic          neg_a;
  logic [NW-1:0] nmag_a;
  logic [DW-1:0] dmag_a;
  logic [NW:0]   n2;
  logic [XW-1:0] hx;

  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] low [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic [DW-1:0] dm  [QW+1];
  logic          ng  [QW+1];
  logic          ov  [QW+1];

  logic [QW:0]   qinc;
  logic [QW-1:0] mag;
  logic          over;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    if (en) begin
      neg_a  <= num[NW-1] ^ den[DW-1];
      nmag_a <= num[NW-1] ? NW'(-num) : NW'(num);
      dmag_a <= den[DW-1] ? DW'(-den) : DW'(den);
    end
  end

  // doubled numerator: top part seeds the remainder, overflow check
  assign n2 = {nmag_a, 1'b0};
  assign hx = XW'(n2[NW:QW]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= hx[DW-1:0];
      low[0] <= n2[QW-1:0];
      quo[0] <= '0;
      dm[0]  <= dmag_a;
      ng[0]  <= neg_a;
      ov[0]  <= hx >= XW'(dmag_a);
    end
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem[s-1], low[s-1][QW-1]};
    assign diff  = trial - {1'b0, dm[s-1]};
    assign ge    = trial >= {1'b0, dm[s-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low[s] <= low[s-1] << 1;
        quo[s] <= {quo[s-1][QW-2:0], ge};
        dm[s]  <= dm[s-1];
        ng[s]  <= ng[s-1];
        ov[s]  <= ov[s-1];
      end
    end
  end

  // round half away from zero, then clip
  assign qinc = (QW+1)'(quo[QW]) + (QW+1)'(1);
  assign mag  = qinc[QW:1];
  assign over = ov[QW] || (ng[QW] ? (mag > LIM_NEG) : (mag > LIM_POS));

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= over;
      if (over) begin
        q <= ng[QW] ? coord_t'(LIM_NEG[W-1:0]) : coord_t'(LIM_POS[W-1:0]);
      end else begin
        q <= ng[QW] ? coord_t'(-mag[W-1:0]) : coord_t'(mag[W-1:0]);
      end
    end
  end

endmodule

>>> rtl/core/parabola_three_point_fit.sv
// a triple passes the numerator pipeline, dividers and output register
// throughput: one transaction per cycle unless the output stalls, set
// by the fully pipelined multiplier banks and one-bit-per-stage dividers
// a stalled output holds the whole pipeline; reset clears all valid bits
// top level of the three-point parabola fit; depends on pft_pkg,
// pft_numer and pft_div

module parabola_three_point_fit #(
  parameter int FRAC_BITS = pft_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_stall,
  input  pft_pkg::point_t points,
  output logic            coef_valid,
  input  logic            coef_stall,
  output pft_pkg::coef_t  coefs
);
  import pft_pkg::*;

  localparam int WA = NA_WIDTH + 2 * FRAC_BITS;
  localparam int WB = NB_WIDTH + FRAC_BITS;
  localparam int WAB = (WA > WB) ? WA : WB;
  localparam int NW = (WAB > NC_WIDTH) ? WAB : NC_WIDTH;

  logic en;

  nflag_t                     nflag;
  logic signed [DEN_WIDTH-1:0] den;
  logic signed [NA_WIDTH-1:0]  na;
  logic signed [NB_WIDTH-1:0]  nb;
  logic signed [NC_WIDTH-1:0]  nc;
  logic signed [NW-1:0]        num_a, num_b, num_c;

  coord_t qa, qb, qc;
  logic   sa, sb, sc;
  nflag_t dfl [DIV_LAT];

  // whole pipeline advances unless the output register is held
  assign en          = !(coef_valid && coef_stall);
  assign point_stall = !en;

  pft_numer u_numer (
    .clk(clk), .rst(rst), .en(en),
    .pt_valid(point_valid), .pt(points),
    .flag(nflag), .den(den), .na(na), .nb(nb), .nc(nc)
  );

  // fixed-point scaling of the numerators
  assign num_a = NW'(na) <<< (2 * FRAC_BITS);
  assign num_b = NW'(nb) <<< FRAC_BITS;
  assign num_c = NW'(nc);

  pft_div #(.NW(NW), .DW(DEN_WIDTH)) u_div_a (
    .clk(clk), .en(en), .num(num_a), .den(den), .q(qa), .sat(sa)
  );
  pft_div #(.NW(NW), .DW(DEN_WIDTH)) u_div_b (
    .clk(clk), .en(en), .num(num_b), .den(den), .q(qb), .sat(sb)
  );
  pft_div #(.NW(NW), .DW(DEN_WIDTH)) u_div_c (
    .clk(clk), .en(en), .num(num_c), .den(den), .q(qc), .sat(sc)
  );

  // flags alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) dfl[k] <= '0;
    end else if (en) begin
      dfl[0] <= nflag;
      for (int k = 1; k < DIV_LAT; k++) dfl[k] <= dfl[k-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= 1'b0;
    end else if (en) begin
      coef_valid <= dfl[DIV_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dfl[DIV_LAT-1].sing) begin
        coefs <= '{coef_square: '0, coef_linear: '0, coef_const: '0,
                   singular: 1'b1, saturated: 1'b0};
      end else begin
        coefs <= '{coef_square: qa, coef_linear: qb, coef_const: qc,
                   singular: 1'b0, saturated: sa || sb || sc};
      end
    end
  end

endmodule

>>> rtl/core/pft_check.sv
// port-level checks for the parabola fit, bound to the top level
// depends on pft_pkg

module pft_check (
  input logic           clk,
  input logic           rst,
  input logic           point_stall,
  input logic           coef_valid,
  input logic           coef_stall,
  input pft_pkg::coef_t coefs
);
  import pft_pkg::*;

  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !coef_valid)
    else $error("result valid right after reset");

  // input is only held back by a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    point_stall |-> (coef_valid && coef_stall))
    else $error("input stalled without a held result");

  // singular result carries zero coefficients and no clipping
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (coef_valid && coefs.singular) |->
      (coefs.coef_square == '0 && coefs.coef_linear == '0 &&
       coefs.coef_const == '0 && !coefs.saturated))
    else $error("singular result with nonzero fields");

  // a clipped result shows at least one coefficient at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (coef_valid && coefs.saturated) |->
      (coefs.coef_square == CMAX || coefs.coef_square == CMIN ||
       coefs.coef_linear == CMAX || coefs.coef_linear == CMIN ||
       coefs.coef_const == CMAX || coefs.coef_const == CMIN))
    else $error("saturated flag without a clipped coefficient");

  // held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (coef_valid && coef_stall) |=> (coef_valid && $stable(coefs)))
    else $error("held result changed");

endmodule

bind parabola_three_point_fit pft_check u_pft_check (.*);

>>> sim/parabola_fit_checker.sv
// checker for the three-point parabola fit: watches both channels,
// predicts the coefficients of each accepted point triple and compares them
// depends on pft_pkg

module parabola_fit_checker
  import pft_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   point_valid,
  input  logic   point_stall,
  input  point_t points,
  input  logic   coef_valid,
  input  logic   coef_stall,
  input  coef_t  coefs,
  output int     errors,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  localparam wide_t COEF_MAX = (wide_t'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam wide_t COEF_MIN_MAG = wide_t'(1) <<< (COORD_WIDTH - 1);

  coef_t coefs_due[$];

  // rounded quotient, ties away from zero, clipped to the coordinate range
  function automatic coord_t round_quotient(wide_t num, wide_t den, inout logic clipped);
    logic  neg;
    wide_t n_mag;
    wide_t d_mag;
    wide_t quo;
    wide_t rem;
    neg = num[255] ^ den[255];
    n_mag = num[255] ? -num : num;
    d_mag = den[255] ? -den : den;
    quo = n_mag / d_mag;
    rem = n_mag % d_mag;
    if ((rem <<< 1) >= d_mag) quo = quo + 1;
    if (neg) begin
      if (quo > COEF_MIN_MAG) begin
        clipped = 1'b1;
        return coord_t'(-COEF_MIN_MAG);
      end
      return coord_t'(-quo);
    end
    if (quo > COEF_MAX) begin
      clipped = 1'b1;
      return coord_t'(COEF_MAX);
    end
    return coord_t'(quo);
  endfunction

  // closed-form solve of the three-point system
  function automatic coef_t fit_parabola(point_t p);
    wide_t u0, u1, u2, v0, v1, v2;
    wide_t d12, d13, d23, den, na, nb, nc;
    logic  clipped;
    coef_t r;
    if (p.mode) begin
      u0 = p.first_y;  v0 = p.first_x;
      u1 = p.second_y; v1 = p.second_x;
      u2 = p.third_y;  v2 = p.third_x;
    end else begin
      u0 = p.first_x;  v0 = p.first_y;
      u1 = p.second_x; v1 = p.second_y;
      u2 = p.third_x;  v2 = p.third_y;
    end
    d12 = u0 - u1;
    d13 = u0 - u2;
    d23 = u1 - u2;
    den = d12 * d13 * d23;
    r = '0;
    if (den == 0) begin
      r.singular = 1'b1;
      return r;
    end
    na = v0 * d23 - v1 * d13 + v2 * d12;
    nb = v0 * (u2 * u2 - u1 * u1) + v1 * (u0 * u0 - u2 * u2) + v2 * (u1 * u1 - u0 * u0);
    nc = v0 * u1 * u2 * d23 - v1 * u2 * u0 * d13 + v2 * u0 * u1 * d12;
    clipped = 1'b0;
    r.coef_square = round_quotient(na <<< (2 * FRAC_BITS_DEF), den, clipped);
    r.coef_linear = round_quotient(nb <<< FRAC_BITS_DEF, den, clipped);
    r.coef_const = round_quotient(nc, den, clipped);
    r.saturated = clipped;
    return r;
  endfunction

  assign pending = coefs_due.size();

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    coef_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (point_valid && !point_stall) coefs_due.push_back(fit_parabola(points));
      if (coef_valid && !coef_stall) begin
        if (coefs_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, coefs);
          errors <= errors + 1;
        end else begin
          want = coefs_due.pop_front();
          if (want !== coefs) begin
            $display("%0t: mismatch expected %h %h %h s%b c%b actual %h %h %h s%b c%b",
                     $time, want.coef_square, want.coef_linear, want.coef_const,
                     want.singular, want.saturated, coefs.coef_square, coefs.coef_linear,
                     coefs.coef_const, coefs.singular, coefs.saturated);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb.sv
// testbench top for the three-point parabola fit: clock, reset, stimulus,
// output stall pattern, watchdog and verdict; depends on pft_pkg,
// parabola_three_point_fit and parabola_fit_checker

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pft_pkg::*;

  localparam int RANDOM_ITEMS = 1030;
  localparam int QUIET_FROM = 880;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  logic   clk;
  logic   rst;
  logic   point_valid;
  logic   point_stall;
  point_t points;
  logic   coef_valid;
  logic   coef_stall;
  coef_t  coefs;
  int     errors;
  int     pending;
  logic   quiet;
  int     idle_cycles;

  parabola_three_point_fit i_dut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .points(points),
    .coef_valid(coef_valid), .coef_stall(coef_stall), .coefs(coefs)
  );

  parabola_fit_checker i_checker (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .points(points),
    .coef_valid(coef_valid), .coef_stall(coef_stall), .coefs(coefs),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one transaction, held until accepted, then a random gap now and then
  task automatic send_points(point_t p);
    points <= p;
    point_valid <= 1'b1;
    do @(posedge clk); while (point_stall);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      point_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // coordinate drawn from a mix of ranges so that few fits saturate
  function automatic coord_t random_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom());
      1: return coord_t'($signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000);
      2: return coord_t'(($signed($urandom_range(0, 16)) - 8) <<< FRAC_BITS_DEF);
      default: return coord_t'($signed($urandom_range(0, 32'h3ff)) - 32'sh200);
    endcase
  endfunction

  function automatic point_t random_points();
    point_t p;
    p.mode = 1'($urandom_range(0, 1));
    p.first_x = random_coord();
    p.first_y = random_coord();
    p.second_x = random_coord();
    p.second_y = random_coord();
    p.third_x = random_coord();
    p.third_y = random_coord();
    // now and then two abscissas coincide
    if ($urandom_range(0, 9) == 0) begin
      if (p.mode) p.third_y = p.first_y;
      else p.second_x = p.third_x;
    end
    return p;
  endfunction

  function automatic point_t make_points(logic m, coord_t x1, coord_t y1, coord_t x2,
                                         coord_t y2, coord_t x3, coord_t y3);
    point_t p;
    p.mode = m;
    p.first_x = x1; p.first_y = y1;
    p.second_x = x2; p.second_y = y2;
    p.third_x = x3; p.third_y = y3;
    return p;
  endfunction

  // output stall in random bursts, none near the end
  initial begin
    coef_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (quiet) begin
        coef_stall <= 1'b0;
        @(posedge clk);
      end else begin
        coef_stall <= $urandom_range(0, 2) == 0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((point_valid && !point_stall) || (coef_valid && !coef_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  localparam coord_t ONE = coord_t'(1) <<< FRAC_BITS_DEF;
  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  initial begin
    rst = 1'b1;
    point_valid = 1'b0;
    points = '0;
    quiet = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: singular, exact fits, extremes, swapped mode, saturation
    send_points('0);
    send_points(make_points(1'b0, 0, 0, ONE, ONE, 2 * ONE, 4 * ONE));
    send_points(make_points(1'b1, 0, 0, ONE, ONE, 4 * ONE, 2 * ONE));
    send_points(make_points(1'b0, -ONE, ONE, 0, 0, ONE, ONE));
    send_points(make_points(1'b0, ONE, 3, ONE, 5, 2 * ONE, 7));
    send_points(make_points(1'b1, 3, ONE, 5, ONE, 7, 2 * ONE));
    send_points(make_points(1'b0, CMIN, CMIN, 0, 0, CMAX, CMAX));
    send_points(make_points(1'b1, CMIN, CMIN, 0, 0, CMAX, CMAX));
    send_points(make_points(1'b0, CMAX, CMIN, CMIN, CMAX, 0, CMIN));
    send_points(make_points(1'b0, 0, CMAX, 1, CMIN, 2, CMAX));
    send_points(make_points(1'b1, CMAX, 0, CMIN, 1, CMAX, 2));
    send_points(make_points(1'b0, 0, 1, 1, 0, 2, 0));
    send_points(make_points(1'b0, 0, 0, 2, 1, 4, 0));
    send_points(make_points(1'b0, -1, -1, -1, -1, -1, -1));
    send_points(make_points(1'b1, '1, 0, '1, 1, 0, 2));
    send_points(make_points(1'b0, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
                            32'h5555_5555, 32'h1234_5678, 32'hedcb_a987));

    // hold off until the pipeline has drained
    point_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == QUIET_FROM) quiet = 1'b1;
      send_points(random_points());
    end
    point_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
